>>> rtl/core/scc_pkg.sv
// package with sizes, types and state encoding of the stokes cross-correlator
package scc_pkg;

  localparam int unsigned Stands   = 16;
  localparam int unsigned Channels = 64;
  localparam int unsigned Sets     = 16;

  localparam int unsigned StandW = $clog2(Stands);
  localparam int unsigned ChanW  = $clog2(Channels);
  localparam int unsigned SetW   = $clog2(Sets);
  localparam int unsigned SmpAw  = StandW + ChanW + SetW;
  localparam int unsigned VldAw  = StandW + SetW;
  localparam int unsigned SmpDepth = Stands * Channels * Sets;
  localparam int unsigned VldDepth = Stands * Sets;

  localparam int unsigned SmpW   = 16;
  localparam int unsigned WordW  = 4 * SmpW;
  localparam int unsigned ProdW  = 2 * SmpW;
  localparam int unsigned OutW   = 40;
  localparam int unsigned CntW   = 5;
  localparam int unsigned Lanes  = 6;
  localparam int unsigned DivBitsPerCycle = 2;
  localparam int unsigned DivSteps = OutW / DivBitsPerCycle;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [CntW-1:0] SetsInUseReset = CntW'(Sets);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef logic signed [OutW-1:0] acc_t;

endpackage

>>> rtl/core/stokes_cross_correlator_top.sv
// stokes cross-correlator: sample memory, per-set multiply-accumulate and divide by valid count
//
// A load word writes one sample pair and its valid bits. A query word reads stand A and stand
// B from the single-port sample memory on alternate cycles for every FFT set in use, then the
// accumulation drains through the read pipeline; the six quotients are then formed in parallel
// at 2 bits per cycle, and the output register is loaded once it is free. With no valid set
// the division is skipped. The input stays stalled until the result is loaded. Memories
// start undefined and have no clearing pass: every entry a query reads must have been loaded
// before.
module stokes_cross_correlator_top
  import scc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [StandW-1:0]        stand_a_i,
  input  logic [StandW-1:0]        stand_b_i,
  input  logic [ChanW-1:0]         channel_i,
  input  logic [SetW-1:0]          set_index_i,
  input  logic signed [SmpW-1:0]   x_real_i,
  input  logic signed [SmpW-1:0]   x_imag_i,
  input  logic signed [SmpW-1:0]   y_real_i,
  input  logic signed [SmpW-1:0]   y_imag_i,
  input  logic                     valid_x_i,
  input  logic                     valid_y_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [OutW-1:0]   i_real_o,
  output logic signed [OutW-1:0]   i_imag_o,
  output logic signed [OutW-1:0]   q_real_o,
  output logic signed [OutW-1:0]   q_imag_o,
  output logic signed [OutW-1:0]   u_real_o,
  output logic signed [OutW-1:0]   u_imag_o,
  output logic signed [OutW-1:0]   v_real_o,
  output logic signed [OutW-1:0]   v_imag_o,
  output logic [CntW-1:0]          valid_count_o,
  output logic                     no_valid_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CntW-1:0]          cfg_data_i
);

  state_e state_q, state_d;

  logic [CntW-1:0] sets_q;
  logic [CntW-1:0] m_sets;
  logic            in_acc;
  logic            load_acc;
  logic            query_acc;

  // query context
  logic [StandW-1:0] sa_q, sb_q;
  logic [ChanW-1:0]  ch_q;
  logic [CntW-1:0]   cnt_q;
  logic              ph_q;
  logic              issue;

  // memories
  logic [WordW-1:0] smem_q [SmpDepth];
  logic [1:0]       vmem_q [VldDepth];
  logic [WordW-1:0] smem_rd_q;
  logic [1:0]       vmem_rd_q;
  logic [SmpAw-1:0] smem_addr;
  logic [VldAw-1:0] vmem_addr;
  logic [StandW-1:0] rd_stand;

  // read pipeline
  logic             rd_a_q, rd_b_q, prod_vld_q;
  logic [WordW-1:0] a_q;
  logic             va_q, both_q;
  logic signed [ProdW-1:0] p_q [12];
  logic signed [SmpW-1:0]  axr, axi, bxr, bxi, byr, byi, ayr, ayi;

  acc_t t1r_q, t1i_q, t2r_q, t2i_q, t3r_q, t3i_q;
  logic [CntW-1:0] n_q;
  logic            drained;

  // divider lanes
  logic [OutW-1:0]    quo_q [Lanes];
  logic [CntW-1:0]    rem_q [Lanes];
  logic [Lanes-1:0]   neg_q;
  logic [OutW-1:0]    quo_d [Lanes];
  logic [CntW-1:0]    rem_d [Lanes];
  logic [DivCntW-1:0] dcnt_q;
  acc_t               num [Lanes];
  acc_t               res [Lanes];

  // output register
  logic            out_valid_q;
  acc_t            o_q [Lanes];
  logic [CntW-1:0] o_cnt_q;
  logic            o_none_q;
  logic            out_load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign load_acc    = in_acc && (action_i == ACT_LOAD);
  assign query_acc   = in_acc && (action_i == ACT_QUERY);

  assign m_sets = (sets_q > CntW'(Sets)) ? CntW'(Sets) : sets_q;
  assign issue  = (state_q == ST_RUN) && (cnt_q < m_sets);
  assign drained = !issue && !rd_a_q && !rd_b_q && !prod_vld_q;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sets_q <= SetsInUseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sets_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (query_acc) state_d = ST_RUN;
      ST_RUN: begin
        if (drained) state_d = (n_q == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV:  if (dcnt_q == DivCntW'(DivSteps)) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sample and valid memories, one access per cycle
  assign rd_stand  = ph_q ? sb_q : sa_q;
  assign smem_addr = load_acc ? {stand_a_i, channel_i, set_index_i}
                              : {rd_stand, ch_q, cnt_q[SetW-1:0]};
  assign vmem_addr = load_acc ? {stand_a_i, set_index_i}
                              : {rd_stand, cnt_q[SetW-1:0]};

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      smem_q[smem_addr] <= {y_imag_i, y_real_i, x_imag_i, x_real_i};
      vmem_q[vmem_addr] <= {valid_y_i, valid_x_i};
    end else if (issue) begin
      smem_rd_q <= smem_q[smem_addr];
      vmem_rd_q <= vmem_q[vmem_addr];
    end
  end

  // read sequencing: stand A on phase 0, stand B on phase 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ph_q       <= 1'b0;
      rd_a_q     <= 1'b0;
      rd_b_q     <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_a_q     <= issue && !ph_q;
      rd_b_q     <= issue && ph_q;
      prod_vld_q <= rd_b_q;
      if (query_acc) begin
        cnt_q <= '0;
        ph_q  <= 1'b0;
      end else if (issue) begin
        ph_q <= !ph_q;
        if (ph_q) cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      sa_q <= stand_a_i;
      sb_q <= stand_b_i;
      ch_q <= channel_i;
    end
  end

  assign axr = a_q[15:0];
  assign axi = a_q[31:16];
  assign ayr = a_q[47:32];
  assign ayi = a_q[63:48];
  assign bxr = smem_rd_q[15:0];
  assign bxi = smem_rd_q[31:16];
  assign byr = smem_rd_q[47:32];
  assign byi = smem_rd_q[63:48];

  always_ff @(posedge clk_i) begin
    if (rd_a_q) begin
      a_q  <= smem_rd_q;
      va_q <= vmem_rd_q[0];
    end
    if (rd_b_q) begin
      both_q <= va_q & vmem_rd_q[1];
      p_q[0]  <= axr * bxr;
      p_q[1]  <= axi * bxi;
      p_q[2]  <= axi * bxr;
      p_q[3]  <= axr * bxi;
      p_q[4]  <= ayr * byr;
      p_q[5]  <= ayi * byi;
      p_q[6]  <= ayi * byr;
      p_q[7]  <= ayr * byi;
      p_q[8]  <= axr * byr;
      p_q[9]  <= axi * byi;
      p_q[10] <= axi * byr;
      p_q[11] <= axr * byi;
    end
  end

  // accumulation; the conj(A_x)*B_y sum mirrors A_x*conj(B_y) so only one is kept
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      t1r_q <= '0;
      t1i_q <= '0;
      t2r_q <= '0;
      t2i_q <= '0;
      t3r_q <= '0;
      t3i_q <= '0;
      n_q   <= '0;
    end else if (prod_vld_q) begin
      t1r_q <= t1r_q + OutW'(p_q[0]) + OutW'(p_q[1]);
      t1i_q <= t1i_q + OutW'(p_q[2]) - OutW'(p_q[3]);
      t2r_q <= t2r_q + OutW'(p_q[4]) + OutW'(p_q[5]);
      t2i_q <= t2i_q + OutW'(p_q[6]) - OutW'(p_q[7]);
      t3r_q <= t3r_q + OutW'(p_q[8]) + OutW'(p_q[9]);
      t3i_q <= t3i_q + OutW'(p_q[10]) - OutW'(p_q[11]);
      n_q   <= n_q + CntW'(both_q);
    end
  end

  // numerators: I, Q real and imag, U real, V real
  assign num[0] = t1r_q + t2r_q;
  assign num[1] = t1i_q + t2i_q;
  assign num[2] = t1r_q - t2r_q;
  assign num[3] = t1i_q - t2i_q;
  assign num[4] = t3r_q <<< 1;
  assign num[5] = t3i_q <<< 1;

  // restoring division of magnitudes, two quotient bits per cycle
  always_comb begin
    logic [CntW:0]   r;
    logic [OutW-1:0] qv;
    for (int l = 0; l < Lanes; l++) begin
      r  = {1'b0, rem_q[l]};
      qv = quo_q[l];
      for (int k = 0; k < DivBitsPerCycle; k++) begin
        r  = {r[CntW-1:0], qv[OutW-1]};
        qv = {qv[OutW-2:0], 1'b0};
        if (r >= {1'b0, n_q}) begin
          r     = r - {1'b0, n_q};
          qv[0] = 1'b1;
        end
      end
      rem_d[l] = r[CntW-1:0];
      quo_d[l] = qv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (state_q == ST_RUN) begin
      dcnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < Lanes; l++) begin
      if (state_q == ST_RUN) begin
        neg_q[l] <= num[l][OutW-1];
        quo_q[l] <= num[l][OutW-1] ? OutW'(-num[l]) : OutW'(num[l]);
        rem_q[l] <= '0;
      end else if (state_q == ST_DIV && dcnt_q != DivCntW'(DivSteps)) begin
        quo_q[l] <= quo_d[l];
        rem_q[l] <= rem_d[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      res[l] = (n_q == '0) ? '0 : (neg_q[l] ? -acc_t'(quo_q[l]) : acc_t'(quo_q[l]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int l = 0; l < Lanes; l++) begin
        o_q[l] <= res[l];
      end
      o_cnt_q  <= n_q;
      o_none_q <= (n_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign i_real_o      = o_q[0];
  assign i_imag_o      = o_q[1];
  assign q_real_o      = o_q[2];
  assign q_imag_o      = o_q[3];
  assign u_real_o      = o_q[4];
  assign u_imag_o      = '0;
  assign v_real_o      = o_q[5];
  assign v_imag_o      = '0;
  assign valid_count_o = o_cnt_q;
  assign no_valid_o    = o_none_q;

endmodule
